[hw/rtl/idp_pkg.sv]
// ----------------------------------------------------------------------------
// idp_pkg
// shared widths, register codes, reset values and helpers for the
// inverse-depth back-projection block
// ----------------------------------------------------------------------------
package idp_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_INV      = 3'd6;

  // field widths
  localparam int SIZE_W  = 11;
  localparam int D_W     = 20;
  localparam int XY_W    = 26;
  localparam int Z_W     = 24;
  localparam int CNT_W   = 21;
  localparam int PROD_W  = 40;
  localparam int FRAC_SH = 30;

  // reset values
  localparam logic [SIZE_W-1:0]     DEF_FRAME_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0]     DEF_FRAME_HEIGHT = 11'd480;
  localparam logic [CFG_DATA_W-1:0] DEF_FOCAL        = 20'd128000;
  localparam logic [CFG_DATA_W-1:0] DEF_CENTER_X     = 20'd81920;
  localparam logic [CFG_DATA_W-1:0] DEF_CENTER_Y     = 20'd61440;
  localparam logic [D_W-1:0]        DEF_MIN_INV      = 20'd66;

  // saturation limits
  localparam logic [XY_W-1:0]  XY_POS_MAX = {1'b0, {(XY_W-1){1'b1}}};
  localparam logic [XY_W-1:0]  XY_NEG_MAX = {1'b1, {(XY_W-1){1'b0}}};
  localparam logic [Z_W-1:0]   Z_MAX      = {Z_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};

  // defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int QUEUE_DEPTH    = 4;

  // queue word: inv depth, column, row, point flag, last flag, count
  function automatic int entry_width(int max_w, int max_h);
    return D_W + $clog2(max_w) + $clog2(max_h) + 2 + CNT_W;
  endfunction

endpackage

[hw/rtl/inverse_depth_to_point_cloud.sv]
// ----------------------------------------------------------------------------
// inverse_depth_to_point_cloud
// back-projects an inverse-depth map, one pixel per word, into 3-d points
// ----------------------------------------------------------------------------
// throughput: skipped pixels at one per cycle while the queue is not full; points
//   one at a time, paced by the 26-step restoring dividers in the back end
// a 4-deep queue lets the front keep taking skipped pixels while a point
//   is being divided
// reset (synchronous, rst_n low): counters clear, registers take defaults
// ----------------------------------------------------------------------------
module inverse_depth_to_point_cloud #(
  parameter int MAX_WIDTH  = idp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = idp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [idp_pkg::D_W-1:0]           in_inv_depth,
  // point words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [idp_pkg::XY_W-1:0]   out_point_x,
  output logic signed [idp_pkg::XY_W-1:0]   out_point_y,
  output logic [idp_pkg::Z_W-1:0]           out_point_z,
  output logic                              out_point_valid,
  output logic                              out_frame_last,
  output logic [idp_pkg::CNT_W-1:0]         out_point_count,
  // register writes
  input  logic                              cfg_we,
  input  logic [idp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [idp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import idp_pkg::*;

  localparam int EW = entry_width(MAX_WIDTH, MAX_HEIGHT);

  // configuration registers
  logic [SIZE_W-1:0]     fw_r, fh_r;
  logic [CFG_DATA_W-1:0] fx_r, fy_r, cx_r, cy_r;
  logic [D_W-1:0]        min_r;

  // queue between front and back
  logic          q_push, q_pop, q_full, q_empty;
  logic [EW-1:0] q_wword, q_rword;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r  <= DEF_FRAME_WIDTH;
      fh_r  <= DEF_FRAME_HEIGHT;
      fx_r  <= DEF_FOCAL;
      fy_r  <= DEF_FOCAL;
      cx_r  <= DEF_CENTER_X;
      cy_r  <= DEF_CENTER_Y;
      min_r <= DEF_MIN_INV;
    end else if (cfg_we) begin
      // out-of-list index falls through and is ignored
      case (cfg_index)
        REG_FRAME_WIDTH:  fw_r  <= cfg_wdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: fh_r  <= cfg_wdata[SIZE_W-1:0];
        REG_FOCAL_X:      fx_r  <= cfg_wdata;
        REG_FOCAL_Y:      fy_r  <= cfg_wdata;
        REG_CENTER_X:     cx_r  <= cfg_wdata;
        REG_CENTER_Y:     cy_r  <= cfg_wdata;
        REG_MIN_INV:      min_r <= cfg_wdata[D_W-1:0];
        default: ;
      endcase
    end
  end

  // front: raster position, threshold test, point count
  idp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_inv_depth  (in_inv_depth),
    .frame_width   (fw_r),
    .frame_height  (fh_r),
    .min_inv_depth (min_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_word        (q_wword)
  );

  idp_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wword),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rword),
    .empty (q_empty)
  );

  // back: products, division, saturation and the output register
  idp_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_word          (q_rword),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .focal_x         (fx_r),
    .focal_y         (fy_r),
    .center_x        (cx_r),
    .center_y        (cy_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_z     (out_point_z),
    .out_point_valid (out_point_valid),
    .out_frame_last  (out_frame_last),
    .out_point_count (out_point_count)
  );

endmodule

[hw/rtl/idp_front.sv]
// ----------------------------------------------------------------------------
// idp_front
// takes pixels, tracks raster position and point count, queues the words
// that need a result
// ----------------------------------------------------------------------------
module idp_front #(
  parameter int MAX_WIDTH  = idp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = idp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_valid,
  output logic                                         in_ready,
  input  logic [idp_pkg::D_W-1:0]                      in_inv_depth,
  input  logic [idp_pkg::SIZE_W-1:0]                   frame_width,
  input  logic [idp_pkg::SIZE_W-1:0]                   frame_height,
  input  logic [idp_pkg::D_W-1:0]                      min_inv_depth,
  input  logic                                         q_full,
  output logic                                         q_push,
  output logic [idp_pkg::entry_width(MAX_WIDTH, MAX_HEIGHT)-1:0] q_word
);
  import idp_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int SWX = (CW + 1 > SIZE_W) ? CW + 1 : SIZE_W;
  localparam int SWY = (RW + 1 > SIZE_W) ? RW + 1 : SIZE_W;

  logic [CW-1:0]    col_r, col_nxt;
  logic [RW-1:0]    row_r, row_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic [SWX-1:0]   w_eff, fw_ext, col_p1;
  logic [SWY-1:0]   h_eff, fh_ext, row_p1;
  logic             row_end, last, pt_valid, accept;

  assign fw_ext = SWX'(frame_width);
  assign fh_ext = SWY'(frame_height);

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    if (frame_width == '0) begin
      w_eff = SWX'(1);
    end else if (fw_ext > SWX'(MAX_WIDTH)) begin
      w_eff = SWX'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
    if (frame_height == '0) begin
      h_eff = SWY'(1);
    end else if (fh_ext > SWY'(MAX_HEIGHT)) begin
      h_eff = SWY'(MAX_HEIGHT);
    end else begin
      h_eff = fh_ext;
    end
  end

  assign col_p1   = SWX'(col_r) + SWX'(1);
  assign row_p1   = SWY'(row_r) + SWY'(1);
  assign row_end  = col_p1 >= w_eff;
  assign last     = row_end && (row_p1 >= h_eff);
  assign pt_valid = in_inv_depth >= min_inv_depth;
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign cnt_inc  = (pt_valid && cnt_r != CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;

  // only points and the frame's last pixel go on to the back end
  assign q_push = accept && (pt_valid || last);
  assign q_word = {in_inv_depth, col_r, row_r, pt_valid, last, cnt_inc};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      if (last) begin
        col_nxt = '0;
        row_nxt = '0;
        cnt_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + RW'(1);
        cnt_nxt = cnt_inc;
      end else begin
        col_nxt = col_r + CW'(1);
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cnt_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hw/rtl/idp_fifo.sv]
// ----------------------------------------------------------------------------
// idp_fifo
// short register queue between front and back end
// ----------------------------------------------------------------------------
module idp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = idp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  import idp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt, rd_r, rd_nxt;
  logic [NW-1:0]    fill_r, fill_nxt;
  logic             do_push, do_pop;

  assign full    = fill_r == NW'(DEPTH);
  assign empty   = fill_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  always_comb begin
    wr_nxt   = wr_r;
    rd_nxt   = rd_r;
    fill_nxt = fill_r;
    if (do_push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + NW'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

[hw/rtl/idp_div.sv]
// ----------------------------------------------------------------------------
// idp_div
// restoring divider, one quotient bit per cycle, with overflow flag
// ----------------------------------------------------------------------------
module idp_div #(
  parameter int NUM_W = 31,
  parameter int DEN_W = 20,
  parameter int Q_W   = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [Q_W-1:0]   quot,
  output logic             ovf
);
  import idp_pkg::*;

  localparam int EW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int KW = $clog2(Q_W);

  logic [EW-1:0]  rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [Q_W-1:0] q_r, q_nxt;
  logic [KW-1:0]  cnt_r, cnt_nxt;
  logic           busy_r, busy_nxt, done_r, done_nxt, ovf_r, ovf_nxt, ge;

  assign ge   = rem_r >= dsr_r;
  assign done = done_r;
  assign quot = q_r;
  assign ovf  = ovf_r;

  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    ovf_nxt  = ovf_r;
    // done holds with the result until the next start
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = EW'(num);
      dsr_nxt  = EW'(den) << (Q_W - 1);
      // quotient would not fit in q_w bits
      ovf_nxt  = EW'(num) >= (EW'(den) << Q_W);
      q_nxt    = '0;
      cnt_nxt  = KW'(Q_W - 1);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = rem_r - dsr_r;
      end
      q_nxt   = {q_r[Q_W-2:0], ge};
      dsr_nxt = dsr_r >> 1;
      cnt_nxt = cnt_r - KW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    ovf_r <= ovf_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

[hw/rtl/idp_back.sv]
// ----------------------------------------------------------------------------
// idp_back
// projects one queued word: products, three dividers, saturation, output
// register
// ----------------------------------------------------------------------------
module idp_back #(
  parameter int MAX_WIDTH  = idp_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = idp_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic [idp_pkg::entry_width(MAX_WIDTH, MAX_HEIGHT)-1:0] q_word,
  input  logic                                         q_empty,
  output logic                                         q_pop,
  input  logic [idp_pkg::CFG_DATA_W-1:0]               focal_x,
  input  logic [idp_pkg::CFG_DATA_W-1:0]               focal_y,
  input  logic [idp_pkg::CFG_DATA_W-1:0]               center_x,
  input  logic [idp_pkg::CFG_DATA_W-1:0]               center_y,
  output logic                                         out_valid,
  input  logic                                         out_ready,
  output logic signed [idp_pkg::XY_W-1:0]              out_point_x,
  output logic signed [idp_pkg::XY_W-1:0]              out_point_y,
  output logic [idp_pkg::Z_W-1:0]                      out_point_z,
  output logic                                         out_point_valid,
  output logic                                         out_frame_last,
  output logic [idp_pkg::CNT_W-1:0]                    out_point_count
);
  import idp_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int PXW = ((CW + 8 > CFG_DATA_W) ? CW + 8 : CFG_DATA_W) + 1;
  localparam int PYW = ((RW + 8 > CFG_DATA_W) ? RW + 8 : CFG_DATA_W) + 1;
  localparam int NXW = PXW - 1 + FRAC_SH + 1;
  localparam int NYW = PYW - 1 + FRAC_SH + 1;
  localparam int NZW = FRAC_SH + 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MUL   = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  logic [1:0]       state_r, state_nxt;

  // latched word
  logic [D_W-1:0]   d_r;
  logic [CW-1:0]    col_r;
  logic [RW-1:0]    row_r;
  logic             pv_r, last_r;
  logic [CNT_W-1:0] cnt_r;

  // product stage
  logic [PROD_W-1:0] denx_r, deny_r;
  logic [PXW-2:0]    magx_r;
  logic [PYW-2:0]    magy_r;
  logic              negx_r, negy_r;

  logic [CFG_DATA_W-1:0] fx_eff, fy_eff;
  logic [PXW-1:0]        diffx, absx;
  logic [PYW-1:0]        diffy, absy;
  logic [NXW-1:0]        numx;
  logic [NYW-1:0]        numy;
  logic [NZW-1:0]        numz;

  logic             div_start, donex, doney, donez, ovfx, ovfy, ovfz;
  logic [XY_W-1:0]  qx, qy;
  logic [XY_W-1:0]  qz;
  logic [XY_W-1:0]  resx, resy;
  logic [Z_W-1:0]   resz;
  logic             load_out;

  logic             out_valid_r, out_valid_nxt;
  logic [XY_W-1:0]  px_r, py_r;
  logic [Z_W-1:0]   pz_r;
  logic             ppv_r, plast_r;
  logic [CNT_W-1:0] pcnt_r;

  assign fx_eff = (focal_x == '0) ? CFG_DATA_W'(1) : focal_x;
  assign fy_eff = (focal_y == '0) ? CFG_DATA_W'(1) : focal_y;

  assign diffx = PXW'({col_r, 8'd0}) - PXW'(center_x);
  assign diffy = PYW'({row_r, 8'd0}) - PYW'(center_y);
  assign absx  = diffx[PXW-1] ? (~diffx + PXW'(1)) : diffx;
  assign absy  = diffy[PYW-1] ? (~diffy + PYW'(1)) : diffy;

  // mag * 2^30 plus half the divisor gives round-to-nearest
  assign numx = NXW'({magx_r, {FRAC_SH{1'b0}}}) + NXW'(denx_r >> 1);
  assign numy = NYW'({magy_r, {FRAC_SH{1'b0}}}) + NYW'(deny_r >> 1);
  assign numz = (NZW'(1) << FRAC_SH) + NZW'(d_r >> 1);

  assign div_start = state_r == ST_START;
  assign q_pop     = state_r == ST_IDLE && !q_empty;
  assign load_out  = state_r == ST_DIV && donex && doney && donez
                     && (!out_valid_r || out_ready);

  idp_div #(.NUM_W(NXW), .DEN_W(PROD_W), .Q_W(XY_W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(numx), .den(denx_r),
    .done(donex), .quot(qx), .ovf(ovfx)
  );

  idp_div #(.NUM_W(NYW), .DEN_W(PROD_W), .Q_W(XY_W)) u_div_y (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(numy), .den(deny_r),
    .done(doney), .quot(qy), .ovf(ovfy)
  );

  idp_div #(.NUM_W(NZW), .DEN_W(D_W), .Q_W(XY_W)) u_div_z (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(numz), .den(d_r),
    .done(donez), .quot(qz), .ovf(ovfz)
  );

  // saturation, sign and the skipped-pixel case
  always_comb begin
    resx = '0;
    resy = '0;
    resz = '0;
    if (pv_r) begin
      if (magx_r == '0) begin
        resx = '0;
      end else if (negx_r) begin
        resx = (ovfx || qx > XY_NEG_MAX) ? XY_NEG_MAX : ('0 - qx);
      end else begin
        resx = (ovfx || qx > XY_POS_MAX) ? XY_POS_MAX : qx;
      end
      if (magy_r == '0) begin
        resy = '0;
      end else if (negy_r) begin
        resy = (ovfy || qy > XY_NEG_MAX) ? XY_NEG_MAX : ('0 - qy);
      end else begin
        resy = (ovfy || qy > XY_POS_MAX) ? XY_POS_MAX : qy;
      end
      resz = (ovfz || qz > XY_W'(Z_MAX)) ? Z_MAX : qz[Z_W-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) state_nxt = ST_MUL;
      end
      ST_MUL:   state_nxt = ST_START;
      ST_START: state_nxt = ST_DIV;
      ST_DIV: begin
        if (load_out) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {d_r, col_r, row_r, pv_r, last_r, cnt_r} <= q_word;
    end
    if (state_r == ST_MUL) begin
      denx_r <= PROD_W'(d_r) * PROD_W'(fx_eff);
      deny_r <= PROD_W'(d_r) * PROD_W'(fy_eff);
      magx_r <= absx[PXW-2:0];
      magy_r <= absy[PYW-2:0];
      negx_r <= diffx[PXW-1];
      negy_r <= diffy[PYW-1];
    end
    if (load_out) begin
      px_r    <= resx;
      py_r    <= resy;
      pz_r    <= resz;
      ppv_r   <= pv_r;
      plast_r <= last_r;
      pcnt_r  <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = px_r;
  assign out_point_y     = py_r;
  assign out_point_z     = pz_r;
  assign out_point_valid = ppv_r;
  assign out_frame_last  = plast_r;
  assign out_point_count = pcnt_r;

endmodule

[hw/rtl/idp_chk.sv]
// ----------------------------------------------------------------------------
// idp_chk
// port-level checks on the point word channel
// ----------------------------------------------------------------------------
module idp_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [idp_pkg::XY_W-1:0] out_point_x,
  input logic signed [idp_pkg::XY_W-1:0] out_point_y,
  input logic [idp_pkg::Z_W-1:0]         out_point_z,
  input logic                            out_point_valid,
  input logic                            out_frame_last,
  input logic [idp_pkg::CNT_W-1:0]       out_point_count
);
  import idp_pkg::*;

  // a stalled word stays valid and holds its depth, count and frame-end flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_point_z)
      && $stable(out_point_count) && $stable(out_frame_last))
    else $error("stalled point word changed");

  // a word without a point only ever closes a frame
  a_skip_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |-> out_frame_last)
    else $error("empty word without frame end");

  // the closing word of a skipped pixel carries zero coordinates
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_point_valid |->
      out_point_x == '0 && out_point_y == '0 && out_point_z == '0)
    else $error("empty word with coordinates");

  // a real point always counts itself
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_valid |-> out_point_count != '0)
    else $error("point with zero count");

  // reset drops the channel
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid after reset");

endmodule

bind inverse_depth_to_point_cloud idp_chk u_idp_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_point_x     (out_point_x),
  .out_point_y     (out_point_y),
  .out_point_z     (out_point_z),
  .out_point_valid (out_point_valid),
  .out_frame_last  (out_frame_last),
  .out_point_count (out_point_count)
);
